### rtl/ole_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list engine package
// Field widths, request and status codes, and the cell operation type.
// ----------------------------------------------------------------------------
package ole_pkg;

	localparam int FUNC_W     = 3;
	localparam int VAL_W      = 32;
	localparam int POS_W      = 5;
	localparam int STS_W      = 2;
	localparam int CNT_OUT_W  = 5;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;

	localparam logic [FUNC_W-1:0] FN_PUSH_HEAD = 3'd0;
	localparam logic [FUNC_W-1:0] FN_POP_HEAD  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_PUSH_TAIL = 3'd2;
	localparam logic [FUNC_W-1:0] FN_POP_TAIL  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_INSERT    = 3'd4;

	localparam logic [STS_W-1:0] STS_DONE   = 2'd0;
	localparam logic [STS_W-1:0] STS_BADPOS = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL   = 2'd2;
	localparam logic [STS_W-1:0] STS_EMPTY  = 2'd3;

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_INS  = 2'd1,
		OP_REM  = 2'd2
	} cell_op_t;

endpackage

### rtl/ole_cell.sv
// ----------------------------------------------------------------------------
// Ordered list engine cell
// Holds one stored value and takes the new value or a neighbor's value.
// ----------------------------------------------------------------------------
module ole_cell #(
	parameter int INDEX = 0,
	parameter int IW    = 4
) (
	input  logic                   clk,
	input  ole_pkg::cell_op_t      op,
	input  logic [IW-1:0]          idx,
	input  logic [ole_pkg::VAL_W-1:0] new_val,
	input  logic [ole_pkg::VAL_W-1:0] left_val,
	input  logic [ole_pkg::VAL_W-1:0] right_val,
	output logic [ole_pkg::VAL_W-1:0] val
);
	import ole_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

	logic [VAL_W-1:0] val_q;

	always_ff @(posedge clk) begin
		case (op)
			OP_INS: begin
				if (MY_IDX == idx) begin
					val_q <= new_val;
				end else if (MY_IDX > idx) begin
					val_q <= left_val;
				end
			end
			OP_REM: begin
				if (MY_IDX >= idx) begin
					val_q <= right_val;
				end
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

	assign val = val_q;

endmodule

### rtl/ole_chain.sv
// ----------------------------------------------------------------------------
// Ordered list engine cell chain
// A row of DEPTH cells; each cell sees its lower and upper neighbor.
// ----------------------------------------------------------------------------
module ole_chain #(
	parameter int DEPTH = 16,
	parameter int IW    = 4
) (
	input  logic                      clk,
	input  ole_pkg::cell_op_t         op,
	input  logic [IW-1:0]             idx,
	input  logic [ole_pkg::VAL_W-1:0] new_val,
	output logic [ole_pkg::VAL_W-1:0] vals [DEPTH]
);
	import ole_pkg::*;

	genvar k;
	generate
		for (k = 0; k < DEPTH; k++) begin : g_cell
			logic [VAL_W-1:0] left_w;
			logic [VAL_W-1:0] right_w;

			// The head cell has no lower neighbor and the last cell none above.
			if (k == 0) begin : g_head
				assign left_w = new_val;
			end else begin : g_mid_l
				assign left_w = vals[k-1];
			end
			if (k == DEPTH - 1) begin : g_last
				assign right_w = vals[k];
			end else begin : g_mid_r
				assign right_w = vals[k+1];
			end

			ole_cell #(
				.INDEX (k),
				.IW    (IW)
			) u_cell (
				.clk       (clk),
				.op        (op),
				.idx       (idx),
				.new_val   (new_val),
				.left_val  (left_w),
				.right_val (right_w),
				.val       (vals[k])
			);
		end
	endgenerate

endmodule

### rtl/ordered_list_engine_core.sv
// ----------------------------------------------------------------------------
// Ordered list engine
// Bounded ordered sequence of signed values with head, tail and indexed edits.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel, one beat per request: push or pop at
// the head, push or pop at the tail, or insert at a 1-based position. Each
// request yields exactly one response beat on m_axis with a status, the
// element count after the request and the wrapping sum of all stored values.
// Refused requests (bad position, full, empty) leave the contents unchanged.
// A request is registered on acceptance together with the current tail value;
// then, in its work cycle, the cell chain shifts in parallel and the response
// register is loaded. No new request is taken until that work cycle is done;
// the response appears the cycle after the work cycle.
// A new request is accepted while the previous response still waits; the work
// cycle then holds until the response register is free, so a stalled receiver
// stops the chain without losing a beat. Reset clears the count, the sum and
// all handshake state; the cell contents are not cleared, since only cells
// below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_list_engine_core #(
	parameter int DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// func[2:0], item_value[34:3], position[39:35]
	input  logic [ole_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// status[1:0], element_count[6:2], value_sum[38:7], zero[39]
	output logic [ole_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import ole_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;

	logic [FUNC_W-1:0] func_s1;
	logic [VAL_W-1:0]  value_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [VAL_W-1:0]  tail_s1;

	logic [CW-1:0]     count_q;
	logic [VAL_W-1:0]  sum_q;
	logic              m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic [VAL_W-1:0]  cell_vals [DEPTH];

	logic              in_fire;
	logic              exec_go;
	logic [STS_W-1:0]  sts;
	cell_op_t          op;
	cell_op_t          chain_op;
	logic [IW-1:0]     idx;
	logic [VAL_W-1:0]  removed;
	logic [VAL_W-1:0]  sum_opnd;
	logic [CW-1:0]     count_next;
	logic [VAL_W-1:0]  sum_next;
	logic [PW-1:0]     cnt_ext;
	logic [PW-1:0]     pos_ext;
	logic              full;
	logic              empty;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid & s_axis_tready;
	assign exec_go       = (state_q == S_EXEC) && (!m_valid_q || m_axis_tready);

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign cnt_ext = PW'(count_q);
	assign pos_ext = PW'(pos_s1);

	always_comb begin
		sts     = STS_DONE;
		op      = OP_HOLD;
		idx     = '0;
		removed = '0;
		case (func_s1)
			FN_PUSH_HEAD: begin
				if (full) begin
					sts = STS_FULL;
				end else begin
					op = OP_INS;
				end
			end
			FN_POP_HEAD: begin
				if (empty) begin
					sts = STS_EMPTY;
				end else begin
					op      = OP_REM;
					removed = cell_vals[0];
				end
			end
			FN_PUSH_TAIL: begin
				if (full) begin
					sts = STS_FULL;
				end else begin
					op  = OP_INS;
					idx = IW'(count_q);
				end
			end
			FN_POP_TAIL: begin
				if (empty) begin
					sts = STS_EMPTY;
				end else begin
					op      = OP_REM;
					idx     = IW'(count_q - CW'(1));
					removed = tail_s1;
				end
			end
			FN_INSERT: begin
				// The position check wins over the full check.
				if (pos_ext == '0 || pos_ext > cnt_ext + PW'(1)) begin
					sts = STS_BADPOS;
				end else if (full) begin
					sts = STS_FULL;
				end else begin
					op  = OP_INS;
					idx = IW'(pos_ext - PW'(1));
				end
			end
			default: begin
				sts = STS_DONE;
			end
		endcase
	end

	always_comb begin
		case (op)
			OP_INS: begin
				count_next = count_q + CW'(1);
				sum_opnd   = value_s1;
			end
			OP_REM: begin
				count_next = count_q - CW'(1);
				sum_opnd   = -removed;
			end
			default: begin
				count_next = count_q;
				sum_opnd   = '0;
			end
		endcase
	end

	assign sum_next = sum_q + sum_opnd;
	assign chain_op = exec_go ? op : OP_HOLD;

	ole_chain #(
		.DEPTH (DEPTH),
		.IW    (IW)
	) u_chain (
		.clk     (clk),
		.op      (chain_op),
		.idx     (idx),
		.new_val (value_s1),
		.vals    (cell_vals)
	);

	// Request capture; the tail is read here while the count is settled.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1  <= s_axis_tdata[FUNC_W-1:0];
			value_s1 <= s_axis_tdata[FUNC_W +: VAL_W];
			pos_s1   <= s_axis_tdata[FUNC_W + VAL_W +: POS_W];
			tail_s1  <= cell_vals[IW'(count_q - CW'(1))];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			sum_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (exec_go) begin
				count_q   <= count_next;
				sum_q     <= sum_next;
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			m_data_q <= {1'b0, sum_next, CNT_OUT_W'(count_next), sts};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

### rtl/ole_checker.sv
// ----------------------------------------------------------------------------
// Ordered list engine port checker
// Watches the stream ports of the engine over time.
// ----------------------------------------------------------------------------
module ole_checker #(
	parameter int DEPTH = 16
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [ole_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import ole_pkg::*;

	localparam logic [CNT_OUT_W-1:0] FULL_CNT = CNT_OUT_W'(DEPTH);

	logic [STS_W-1:0]     sts;
	logic [CNT_OUT_W-1:0] cnt;

	assign sts = m_axis_tdata[STS_W-1:0];
	assign cnt = m_axis_tdata[STS_W +: CNT_OUT_W];

	// A stalled response beat keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("response beat changed while stalled");

	// Each request needs a work cycle before the next one is taken.
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted in the work cycle");

	// An empty refusal reports no elements.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && sts == STS_EMPTY |-> cnt == '0)
		else $error("empty status with nonzero count");

	// A full refusal reports the store depth.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && sts == STS_FULL |-> cnt == FULL_CNT)
		else $error("full status with count below depth");

	// The padding bit of a response is always zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1] == 1'b0)
		else $error("response padding bit set");

endmodule

bind ordered_list_engine_core ole_checker #(
	.DEPTH (DEPTH)
) u_ole_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered list engine testbench
// Drives head, tail and indexed edits into the core over the request stream.
// A queue-based copy of the list predicts each response beat, and every
// response is checked field by field against the oldest prediction. Both
// stream sides idle at random, and the receiver also holds off for a long
// stretch so that the core stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
	import ole_pkg::*;

	localparam int DEPTH = 16;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
	localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = 3'd7;

	// One response beat, laid out as on m_axis_tdata (status in the low bits).
	typedef struct packed {
		logic             pad;
		logic [VAL_W-1:0] sum;
		logic [4:0]       cnt;
		logic [STS_W-1:0] status;
	} list_reply_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	logic [VAL_W-1:0] stored_values[$];
	logic [VAL_W-1:0] stored_sum;
	list_reply_t      pending_replies[$];
	int               fault_count;
	int               mismatch_count;
	bit               tx_idle_on;
	bit               rx_idle_on;
	int               rx_hold_cycles;

	ordered_list_engine_core #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one request to the list copy and returns the response it must give.
	function automatic list_reply_t predict_request(input logic [FUNC_W-1:0] fn,
		input logic [VAL_W-1:0] value, input logic [POS_W-1:0] pos);
		list_reply_t reply;
		int          fill;
		fill = stored_values.size();
		reply.status = STS_DONE;
		case (fn)
			FN_PUSH_HEAD, FN_PUSH_TAIL: begin
				if (fill >= DEPTH) begin
					reply.status = STS_FULL;
				end else begin
					if (fn == FN_PUSH_HEAD) stored_values.push_front(value);
					else stored_values.push_back(value);
					stored_sum = stored_sum + value;
				end
			end
			FN_POP_HEAD, FN_POP_TAIL: begin
				if (fill == 0) begin
					reply.status = STS_EMPTY;
				end else if (fn == FN_POP_HEAD) begin
					stored_sum = stored_sum - stored_values.pop_front();
				end else begin
					stored_sum = stored_sum - stored_values.pop_back();
				end
			end
			FN_INSERT: begin
				// The position check wins over the full check.
				if (pos == '0 || int'(pos) > fill + 1) begin
					reply.status = STS_BADPOS;
				end else if (fill >= DEPTH) begin
					reply.status = STS_FULL;
				end else begin
					stored_values.insert(int'(pos) - 1, value);
					stored_sum = stored_sum + value;
				end
			end
			default: begin
			end
		endcase
		reply.pad = 1'b0;
		reply.cnt = 5'(stored_values.size());
		reply.sum = stored_sum;
		return reply;
	endfunction

	// Extremes show up often; the rest is a full random word.
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic issue_request(input logic [FUNC_W-1:0] fn, input logic [VAL_W-1:0] value,
		input logic [POS_W-1:0] pos);
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {pos, value, fn};
		do @(posedge clk); while (!s_axis_tready);
		pending_replies.push_back(predict_request(fn, value, pos));
	endtask

	// The sender stops offering beats until every response has come back.
	task automatic wait_all_replies();
		s_axis_tvalid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed_edges();
		issue_request(FN_POP_HEAD, 32'h0, 5'd0);
		issue_request(FN_POP_TAIL, 32'hFFFF_FFFF, 5'd31);
		for (int f = FN_SPARE_FIRST; f <= FN_SPARE_LAST; f++) begin
			issue_request(FUNC_W'(f), 32'hFFFF_FFFF, 5'd31);
		end
		issue_request(FN_INSERT, 32'h1234_5678, 5'd0);
		issue_request(FN_INSERT, 32'h1234_5678, 5'd2);
		issue_request(FN_INSERT, 32'h8000_0000, 5'd1);
		issue_request(FN_PUSH_HEAD, 32'h7FFF_FFFF, 5'd0);
		issue_request(FN_PUSH_TAIL, 32'hFFFF_FFFF, 5'd0);
		// Insert at count plus one lands at the tail.
		issue_request(FN_INSERT, 32'h0000_0000, 5'd4);
		issue_request(FN_INSERT, 32'h0000_0001, 5'd2);
		issue_request(FN_INSERT, 32'hDEAD_BEEF, 5'd7);
		issue_request(FN_INSERT, 32'h8000_0000, 5'd6);
		issue_request(FN_POP_HEAD, 32'h0, 5'd0);
		issue_request(FN_POP_TAIL, 32'h0, 5'd0);
		issue_request(FN_INSERT, 32'h5555_5555, 5'd3);
		for (int f = FN_SPARE_FIRST; f <= FN_SPARE_LAST; f++) begin
			issue_request(FUNC_W'(f), 32'h0, 5'd0);
		end
		wait_all_replies();
	endtask

	task automatic test_full_store();
		logic [FUNC_W-1:0] fn;
		while (stored_values.size() < DEPTH) begin
			case ($urandom_range(0, 2))
				0: fn = FN_PUSH_HEAD;
				1: fn = FN_PUSH_TAIL;
				default: fn = FN_INSERT;
			endcase
			issue_request(fn, pick_value(),
				POS_W'($urandom_range(1, stored_values.size() + 1)));
		end
		issue_request(FN_PUSH_HEAD, pick_value(), 5'd1);
		issue_request(FN_PUSH_TAIL, pick_value(), 5'd1);
		issue_request(FN_INSERT, pick_value(), 5'd1);
		issue_request(FN_INSERT, pick_value(), 5'd17);
		issue_request(FN_INSERT, pick_value(), 5'd18);
		issue_request(FN_INSERT, pick_value(), 5'd0);
		while (stored_values.size() != 0) begin
			issue_request($urandom_range(0, 1) ? FN_POP_HEAD : FN_POP_TAIL,
				pick_value(), POS_W'($urandom));
		end
		issue_request(FN_POP_TAIL, pick_value(), 5'd0);
		issue_request(FN_POP_HEAD, pick_value(), 5'd0);
		wait_all_replies();
	endtask

	// The receiver holds off while beats keep coming, so the core fills and
	// stalls its input.
	task automatic test_backpressure();
		bit saved_idle;
		saved_idle = tx_idle_on;
		tx_idle_on = 1'b0;
		rx_hold_cycles = 80;
		for (int i = 0; i < 12; i++) begin
			issue_request($urandom_range(0, 1) ? FN_PUSH_TAIL : FN_INSERT, pick_value(),
				POS_W'($urandom_range(1, stored_values.size() + 1)));
		end
		tx_idle_on = saved_idle;
		wait_all_replies();
	endtask

	// Mostly well-formed requests; the mix leans toward growth when the list is
	// short and toward removal when it is long, so every fill level is visited.
	task automatic test_random_mix(input int n_items);
		int                roll;
		int                grow;
		logic [FUNC_W-1:0] fn;
		logic [POS_W-1:0]  pos;
		for (int i = 0; i < n_items; i++) begin
			grow = (stored_values.size() < 4) ? 70 : (stored_values.size() > 12) ? 35 : 52;
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				fn = FUNC_W'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
			end else if (roll < 3 + grow) begin
				case ($urandom_range(0, 2))
					0: fn = FN_PUSH_HEAD;
					1: fn = FN_PUSH_TAIL;
					default: fn = FN_INSERT;
				endcase
			end else begin
				fn = $urandom_range(0, 1) ? FN_POP_HEAD : FN_POP_TAIL;
			end
			if ($urandom_range(0, 9) < 8)
				pos = POS_W'($urandom_range(1, stored_values.size() + 1));
			else
				pos = POS_W'($urandom);
			issue_request(fn, pick_value(), pos);
		end
	endtask

	initial begin : receiver
		forever begin
			@(posedge clk);
			if (rx_hold_cycles != 0) begin
				m_axis_tready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
				m_axis_tready <= 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		list_reply_t seen;
		list_reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen = m_axis_tdata;
			if (pending_replies.size() == 0) begin
				fault_count++;
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("response beat with nothing expected: %h", seen);
			end else begin
				want = pending_replies.pop_front();
				if (seen.status !== want.status || seen.cnt !== want.cnt ||
					seen.sum !== want.sum || seen.pad !== want.pad) begin
					fault_count++;
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch: status %0d/%0d count %0d/%0d sum %h/%h pad %b/%b %s",
							want.status, seen.status, want.cnt, seen.cnt,
							want.sum, seen.sum, want.pad, seen.pad, "(expected/actual)");
				end
			end
		end
	end

	initial begin : watchdog
		#3_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin : stimulus
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		m_axis_tready  = 1'b0;
		stored_sum     = '0;
		fault_count    = 0;
		mismatch_count = 0;
		rx_hold_cycles = 0;
		tx_idle_on     = 1'b1;
		rx_idle_on     = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_full_store();
		test_backpressure();
		test_random_mix(760);
		wait_all_replies();
		// Last stretch runs at full rate on both sides.
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		test_random_mix(100);

		wait_all_replies();
		repeat (DRAIN_CYCLES) @(posedge clk);
		fault_count += pending_replies.size();
		if (fault_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
